// ===== rtl/mcr_pkg.sv =====
package mcr_pkg;

    // field widths of the stream words
    localparam int COORD_W  = 16;
    localparam int RADIUS_W = 15;
    localparam int COLOR_W  = 16;
    localparam int OFFS_W   = 16;
    localparam int DEC_W    = 18;

    // default coordinate wrap width
    localparam int COORD_BITS_DEF = 16;

    // input word layout, lowest field first
    localparam int S_TDATA_W = 64;
    localparam int CX_LSB    = 0;
    localparam int CY_LSB    = CX_LSB + COORD_W;
    localparam int RAD_LSB   = CY_LSB + COORD_W;
    localparam int COL_LSB   = RAD_LSB + RADIUS_W;

    // output word layout
    localparam int M_TDATA_W = 48;

    // job queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // item kinds carried in s_tuser
    localparam logic MODE_START = 1'b0;
    localparam logic MODE_STEP  = 1'b1;

    // last pixel index of each job kind
    localparam logic [2:0] LAST_START_IDX = 3'd3;
    localparam logic [2:0] LAST_STEP_IDX  = 3'd7;

    // job word: center x/y, offsets a/b, color, step flag, done flag
    function automatic int job_bits(input int coord_bits);
        return 4 * coord_bits + COLOR_W + 2;
    endfunction

endpackage

// ===== rtl/midpoint_circle_rasterizer.sv =====
// Midpoint circle outline generator.
// Input words on the s_ channel: s_tuser selects start (0) or step (1). A start
// word loads center, radius and color and yields the four axis pixels; a step
// word runs one midpoint iteration and yields eight octant pixels. A step once
// the outline is done, or before any start, is taken and yields nothing.
// Output words on the m_ channel carry one pixel each; m_tlast marks the last
// pixel of an input word and m_tuser is set when the outline is complete.
// With the sequencer idle, an input word that is taken is written into the job
// queue, and its first pixel is then registered into the output word. Pixels
// go out at one per cycle, from a single pixel adder pair, while m_tready is
// high and the job queue holds a job.
// A two-entry job queue sits between the input decoder and the pixel
// sequencer, so input words are taken while earlier pixels are still going
// out; s_tready drops only when that queue is full.
// When m_tready is low with a pixel on m_tvalid, the output word holds and the sequencer waits.
// Reset (aresetn low, synchronous) clears the circle state, empties the queue
// and drops m_tvalid.
module midpoint_circle_rasterizer
    import mcr_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // center_x[15:0], center_y[31:16], radius[46:32], color[62:47], zero[63]
    input  logic [S_TDATA_W-1:0] s_tdata,
    // mode
    input  logic                 s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // pixel_x[15:0], pixel_y[31:16], pixel_color[47:32]
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic                 m_tlast,
    // done_res
    output logic                 m_tuser
);

    localparam int JOB_W = job_bits(COORD_BITS);

    logic             q_push;
    logic             q_full;
    logic             q_pop;
    logic             q_valid;
    logic [JOB_W-1:0] q_wdata;
    logic [JOB_W-1:0] q_rdata;

    mcr_front #(
        .COORD_BITS(COORD_BITS)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_wdata  (q_wdata)
    );

    mcr_queue #(
        .WIDTH(JOB_W)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .wdata   (q_wdata),
        .full    (q_full),
        .pop     (q_pop),
        .valid   (q_valid),
        .rdata   (q_rdata)
    );

    mcr_back #(
        .COORD_BITS(COORD_BITS)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_rdata  (q_rdata),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

// ===== rtl/mcr_front.sv =====
module mcr_front
    import mcr_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [S_TDATA_W-1:0]                s_tdata,
    input  logic                                s_tuser,
    input  logic                                q_full,
    output logic                                q_push,
    output logic [job_bits(COORD_BITS)-1:0]     q_wdata
);

    typedef struct packed {
        logic [COORD_BITS-1:0] cx;
        logic [COORD_BITS-1:0] cy;
        logic [COORD_BITS-1:0] a;
        logic [COORD_BITS-1:0] b;
        logic [COLOR_W-1:0]    color;
        logic                  is_step;
        logic                  done;
    } job_t;

    logic [COORD_BITS-1:0] cx_reg, cx_next;
    logic [COORD_BITS-1:0] cy_reg, cy_next;
    logic [COLOR_W-1:0]    color_reg, color_next;
    logic [OFFS_W-1:0]     ox_reg, ox_next;
    logic [OFFS_W-1:0]     oy_reg, oy_next;
    logic [DEC_W-1:0]      dec_reg, dec_next;
    logic [DEC_W-1:0]      ix_reg, ix_next;
    logic [DEC_W-1:0]      iy_reg, iy_next;
    logic                  run_reg, run_next;

    logic                  accept;
    logic [OFFS_W-1:0]     in_rad;
    logic                  dec_pos;
    logic [DEC_W-1:0]      iy_step;
    logic [DEC_W-1:0]      dec_mid;
    logic [DEC_W-1:0]      ix_step;
    logic [OFFS_W-1:0]     ox_step;
    logic [OFFS_W-1:0]     oy_step;
    job_t                  job;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;
    assign in_rad   = OFFS_W'(s_tdata[RAD_LSB +: RADIUS_W]);

    // one midpoint iteration
    always_comb begin
        dec_pos = !dec_reg[DEC_W-1];
        iy_step = dec_pos ? iy_reg + DEC_W'(2) : iy_reg;
        dec_mid = dec_pos ? dec_reg + iy_step : dec_reg;
        oy_step = dec_pos ? oy_reg - OFFS_W'(1) : oy_reg;
        ix_step = ix_reg + DEC_W'(2);
        ox_step = ox_reg + OFFS_W'(1);
    end

    // state update and job build
    always_comb begin
        cx_next    = cx_reg;
        cy_next    = cy_reg;
        color_next = color_reg;
        ox_next    = ox_reg;
        oy_next    = oy_reg;
        dec_next   = dec_reg;
        ix_next    = ix_reg;
        iy_next    = iy_reg;
        run_next   = run_reg;
        q_push     = 1'b0;
        if (accept) begin
            if (s_tuser == MODE_START) begin
                cx_next    = s_tdata[CX_LSB +: COORD_BITS];
                cy_next    = s_tdata[CY_LSB +: COORD_BITS];
                color_next = s_tdata[COL_LSB +: COLOR_W];
                ox_next    = '0;
                oy_next    = in_rad;
                dec_next   = DEC_W'(1) - DEC_W'(in_rad);
                ix_next    = DEC_W'(1);
                iy_next    = '0 - (DEC_W'(in_rad) << 1);
                run_next   = (in_rad != '0);
                q_push     = 1'b1;
            end else if (run_reg) begin
                ox_next  = ox_step;
                oy_next  = oy_step;
                iy_next  = iy_step;
                ix_next  = ix_step;
                dec_next = dec_mid + ix_step;
                run_next = (ox_step < oy_step);
                q_push   = 1'b1;
            end
        end
        job.cx      = cx_next;
        job.cy      = cy_next;
        job.a       = ox_next[COORD_BITS-1:0];
        job.b       = oy_next[COORD_BITS-1:0];
        job.color   = color_next;
        job.is_step = (s_tuser == MODE_STEP);
        job.done    = !run_next;
    end

    assign q_wdata = job;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cx_reg    <= '0;
            cy_reg    <= '0;
            color_reg <= '0;
            ox_reg    <= '0;
            oy_reg    <= '0;
            dec_reg   <= '0;
            ix_reg    <= '0;
            iy_reg    <= '0;
            run_reg   <= 1'b0;
        end else begin
            cx_reg    <= cx_next;
            cy_reg    <= cy_next;
            color_reg <= color_next;
            ox_reg    <= ox_next;
            oy_reg    <= oy_next;
            dec_reg   <= dec_next;
            ix_reg    <= ix_next;
            iy_reg    <= iy_next;
            run_reg   <= run_next;
        end
    end

endmodule

// ===== rtl/mcr_queue.sv =====
module mcr_queue
    import mcr_pkg::*;
#(
    parameter int WIDTH = 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic             valid,
    output logic [WIDTH-1:0] rdata
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full  = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign valid = (count_reg != '0);
    assign rdata = mem_reg[rd_ptr_reg];

    // pointer and fill count
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                  : wr_ptr_reg + PTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                  : rd_ptr_reg + PTR_W'(1);
        end
        count_next = count_reg + CNT_W'(push) - CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

`ifndef SYNTHESIS
    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !full)
        else $error("job pushed into full queue");
    a_no_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> valid)
        else $error("job popped from empty queue");
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("queue fill count beyond depth");
`endif

endmodule

// ===== rtl/mcr_back.sv =====
module mcr_back
    import mcr_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            q_valid,
    input  logic [job_bits(COORD_BITS)-1:0] q_rdata,
    output logic                            q_pop,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [M_TDATA_W-1:0]            m_tdata,
    output logic                            m_tlast,
    output logic                            m_tuser
);

    typedef struct packed {
        logic [COORD_BITS-1:0] cx;
        logic [COORD_BITS-1:0] cy;
        logic [COORD_BITS-1:0] a;
        logic [COORD_BITS-1:0] b;
        logic [COLOR_W-1:0]    color;
        logic                  is_step;
        logic                  done;
    } job_t;

    job_t                  job;
    logic [2:0]            idx_reg, idx_next;
    logic                  valid_reg, valid_next;
    logic [COORD_W-1:0]    px_reg, py_reg;
    logic [COLOR_W-1:0]    color_reg;
    logic                  last_reg, done_reg;

    logic                  advance;
    logic                  is_last;
    logic [2:0]            sel;
    logic [COORD_BITS-1:0] xs, ys;
    logic [COORD_BITS-1:0] px, py;

    assign job     = q_rdata;
    assign advance = q_valid && (!valid_reg || m_tready);
    assign is_last = job.is_step ? (idx_reg == LAST_STEP_IDX) : (idx_reg == LAST_START_IDX);
    assign q_pop   = advance && is_last;

    // octant select: bit 2 swaps a and b, bit 1 negates y, bit 0 negates x
    always_comb begin
        if (job.is_step) begin
            sel = idx_reg;
        end else begin
            sel = {idx_reg[1], !idx_reg[1] && idx_reg[0], idx_reg[1] && idx_reg[0]};
        end
        xs = sel[2] ? job.b : job.a;
        ys = sel[2] ? job.a : job.b;
        px = job.cx + (xs ^ {COORD_BITS{sel[0]}}) + COORD_BITS'(sel[0]);
        py = job.cy + (ys ^ {COORD_BITS{sel[1]}}) + COORD_BITS'(sel[1]);
    end

    // pixel counter and output register control
    always_comb begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        if (advance) begin
            idx_next   = is_last ? 3'd0 : idx_reg + 3'd1;
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    // output word, sign-extended from the wrap width
    always_ff @(posedge aclk) begin
        if (advance) begin
            px_reg    <= COORD_W'($signed(px));
            py_reg    <= COORD_W'($signed(py));
            color_reg <= job.color;
            last_reg  <= is_last;
            done_reg  <= job.done;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {color_reg, py_reg, px_reg};
    assign m_tlast  = last_reg;
    assign m_tuser  = done_reg;

`ifndef SYNTHESIS
    a_idx_needs_job: assert property (@(posedge aclk) disable iff (!aresetn)
        (idx_reg != 3'd0) |-> q_valid)
        else $error("pixel counter running without a job");
    a_start_four: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_valid && !job.is_step) |-> (idx_reg <= LAST_START_IDX))
        else $error("start job beyond its fourth pixel");
    a_hold_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg && !m_tready) |=> (valid_reg && $stable(idx_reg)))
        else $error("pixel sequencer moved while output stalled");
`endif

endmodule
